/* src/amcd_pkg.sv */
// Shared types and constants for the ASCII motor command decoder.
// Holds the classified-op, configuration and result types that the modules use.
// No dependencies.
package amcd_pkg;

	// Sizes
	localparam int NUM_CHANNELS_DEF = 8;
	localparam int VALUE_BITS_DEF   = 16;
	localparam int MAX_CHANNELS     = 8;
	localparam int CH_W             = 3;
	localparam int NUM_FIELDS       = 16;
	localparam int INDEX_SAT        = NUM_FIELDS + 1;
	localparam int FIELD_IDX_W      = 5;
	localparam int PULSE_W          = 16;
	localparam int TICK_W           = 16;
	localparam int TIMEOUT_W        = 15;
	localparam int QUEUE_DEPTH      = 2;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 16;

	// Input command codes
	localparam logic [1:0] CMD_BYTE   = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_SWITCH = 2'd2;

	// Frame characters
	localparam logic [7:0] CHAR_M     = 8'h4D;
	localparam logic [7:0] CHAR_E     = 8'h45;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GATED       = 2'd3;

	// Register reset values
	localparam logic [MAX_CHANNELS-1:0] RST_ENABLE_MASK = 8'd127;
	localparam logic [TIMEOUT_W-1:0]    RST_TIMEOUT     = 15'd1000;
	localparam logic [PULSE_W-1:0]      RST_PERIOD      = 16'd1000;
	localparam logic [CH_W-1:0]         RST_GATED       = 3'd4;

	typedef enum logic [2:0] {
		OP_MARK,
		OP_DIGIT,
		OP_COLON,
		OP_END,
		OP_TICK,
		OP_SWITCH,
		OP_NONE
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [3:0] digit;
		logic       sw_sel;
		logic       sw_pressed;
	} op_t;

	typedef struct packed {
		logic [MAX_CHANNELS-1:0] enable_mask;
		logic [TIMEOUT_W-1:0]    timeout;
		logic [PULSE_W-1:0]      period;
		logic [CH_W-1:0]         gated;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic               direction;
		logic [PULSE_W-1:0] pulse_width;
		logic               last;
	} result_t;

endpackage

/* src/ascii_motor_command_decoder_top.sv */
// Top level of the ASCII motor command decoder: configuration registers, front
// end, op queue and back end. Depends on amcd_pkg, amcd_front, amcd_queue, amcd_back.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  s_tuser: command; s_tdata: byte, switch
//   m_*       out        m_tvalid / m_tready  m_tdata: channel, dir, pulse; m_tlast
//   cfg_*     in         cfg_wen (no wait)    cfg_index, cfg_wdata
//
// Most byte, tick and switch ops are executed in the idle state; a switch press
// that emits waits for the result register to free up.
// An 'E' byte is taken in the idle state, reads the gated channel in the prep
// state, steps through the channel slots up to the highest emitting channel, then
// closes the frame. A watchdog timeout scans the same way without the read step;
// each held-off result stalls the scan until the output register frees up.
// The two-entry op queue lets the input side keep accepting while the back end
// scans or the output stalls. Reset is asynchronous; no clearing pass is needed.
module ascii_motor_command_decoder_top #(
	parameter int NUM_CHANNELS = amcd_pkg::NUM_CHANNELS_DEF,
	parameter int VALUE_BITS   = amcd_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [1:0]                     s_tuser,   // [1:0] command
	input  logic [15:0]                    s_tdata,   // [7:0] rx_byte, [8] switch_select,
	                                                  // [9] switch_level, rest zero
	// Result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,   // [2:0] channel, [3] direction,
	                                                  // [19:4] pulse_width, rest zero
	output logic                           m_tlast,
	// Configuration writes
	input  logic                           cfg_wen,
	input  logic [amcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [amcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import amcd_pkg::*;

	cfg_t    cfg_q;
	op_t     front_op, queue_op;
	logic    q_push, q_full, q_valid, q_pop;
	result_t res;

	// Configuration registers: write-only, taken on any cycle with cfg_wen high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask <= RST_ENABLE_MASK;
			cfg_q.timeout     <= RST_TIMEOUT;
			cfg_q.period      <= RST_PERIOD;
			cfg_q.gated       <= RST_GATED;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ENABLE_MASK: cfg_q.enable_mask <= cfg_wdata[MAX_CHANNELS-1:0];
				REG_TIMEOUT:     cfg_q.timeout     <= cfg_wdata[TIMEOUT_W-1:0];
				REG_PERIOD:      cfg_q.period      <= cfg_wdata[PULSE_W-1:0];
				REG_GATED:       cfg_q.gated       <= cfg_wdata[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Classify each request and drop stray bytes and unused commands.
	amcd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (front_op)
	);

	// Hold classified ops until the back end is free.
	amcd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (front_op),
		.full    (q_full),
		.valid   (q_valid),
		.pop     (q_pop),
		.pop_op  (queue_op)
	);

	// Execute ops and advance through channel updates one at a time.
	amcd_back #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.VALUE_BITS   (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op_valid  (q_valid),
		.op_pop    (q_pop),
		.op        (queue_op),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result; the last flag travels on tlast.
	assign m_tdata = {4'b0000, res.pulse_width, res.direction, res.channel};
	assign m_tlast = res.last;

endmodule

/* src/amcd_front.sv */
// Front end: accepts input items and classifies them into ops for the queue.
// Depends on amcd_pkg.
module amcd_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        s_tuser,
	input  logic [15:0]       s_tdata,
	input  logic              q_full,
	output logic              q_push,
	output amcd_pkg::op_t     q_op
);
	import amcd_pkg::*;

	logic [7:0] rx_byte;
	logic [7:0] digit_val;

	assign rx_byte   = s_tdata[7:0];
	assign digit_val = rx_byte - CHAR_ZERO;

	always_comb begin
		q_op.kind       = OP_NONE;
		q_op.digit      = digit_val[3:0];
		q_op.sw_sel     = s_tdata[8];
		q_op.sw_pressed = ~s_tdata[9];
		unique case (s_tuser)
			CMD_BYTE: begin
				if (rx_byte == CHAR_M) begin
					q_op.kind = OP_MARK;
				end else if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
					q_op.kind = OP_DIGIT;
				end else if (rx_byte == CHAR_COLON) begin
					q_op.kind = OP_COLON;
				end else if (rx_byte == CHAR_E) begin
					q_op.kind = OP_END;
				end
			end
			CMD_TICK:   q_op.kind = OP_TICK;
			CMD_SWITCH: q_op.kind = OP_SWITCH;
			default:    q_op.kind = OP_NONE;
		endcase
	end

	// Take every item while there is room; drop those that classify to no op.
	assign s_tready = ~q_full;
	assign q_push   = s_tvalid & ~q_full & (q_op.kind != OP_NONE);

endmodule

/* src/amcd_queue.sv */
// Short op queue between the front end and the back end.
// Depends on amcd_pkg.
module amcd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  amcd_pkg::op_t push_op,
	output logic          full,
	output logic          valid,
	input  logic          pop,
	output amcd_pkg::op_t pop_op
);
	import amcd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign pop_op  = slot_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/amcd_back.sv */
// Back end: executes classified ops, holds the frame fields, switch and watchdog
// state, and drives the result register. Depends on amcd_pkg.
module amcd_back #(
	parameter int NUM_CHANNELS = amcd_pkg::NUM_CHANNELS_DEF,
	parameter int VALUE_BITS   = amcd_pkg::VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  amcd_pkg::cfg_t    cfg,
	input  logic              op_valid,
	output logic              op_pop,
	input  amcd_pkg::op_t     op,
	output logic              res_valid,
	input  logic              res_ready,
	output amcd_pkg::result_t res
);
	import amcd_pkg::*;

	localparam int CH_LIMIT = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS : MAX_CHANNELS;
	localparam logic [MAX_CHANNELS-1:0] LIMIT_MASK =
		MAX_CHANNELS'((17'd1 << CH_LIMIT) - 17'd1);
	localparam int ROWS   = NUM_FIELDS / 2;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int FSEL_W = $clog2(NUM_FIELDS);
	localparam int PROD_W = VALUE_BITS + 4;
	localparam int CMP_W  = (VALUE_BITS > PULSE_W) ? VALUE_BITS : PULSE_W;
	localparam logic [PROD_W-1:0] MAXV_EXT = {4'b0000, {VALUE_BITS{1'b1}}};
	localparam logic [MAX_CHANNELS-1:0] ONE_CH = MAX_CHANNELS'(1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	typedef enum logic {
		MODE_FRAME,
		MODE_WDOG
	} mode_t;

	typedef logic [VALUE_BITS-1:0] value_t;

	value_t                  even_q [ROWS];
	value_t                  odd_q  [ROWS];
	logic [FIELD_IDX_W-1:0]  idx_q;
	logic [MAX_CHANNELS-1:0] dir_q;
	logic [MAX_CHANNELS-1:0] mask_q;
	logic                    frame_seen_q, upper_q, lower_q;
	logic [TICK_W-1:0]       tick_q;
	logic [CH_W-1:0]         chan_q;
	state_t                  state_q;
	mode_t                   mode_q;
	logic                    res_valid_q;
	result_t                 res_q;

	logic [MAX_CHANNELS-1:0] en_mask, ch_oh, gate_oh, rest;
	logic [FIELD_IDX_W-1:0]  idx_m1;
	logic [FSEL_W-1:0]       field_sel;
	logic [ROW_W-1:0]        rd_row;
	value_t                  rd_even, rd_odd, cur, sat;
	logic [PROD_W-1:0]       prod;
	logic                    digit_ok, out_free, sw_emit, blocked, tick_over, res_load;
	logic [TICK_W-1:0]       tick_next;
	logic [PULSE_W-1:0]      pw_clamped;
	logic [CMP_W-1:0]        odd_ext, period_ext;

	assign en_mask   = cfg.enable_mask & LIMIT_MASK;
	assign idx_m1    = idx_q - 1'b1;
	assign field_sel = idx_m1[FSEL_W-1:0];
	assign digit_ok  = (idx_q != '0) && (idx_q <= FIELD_IDX_W'(NUM_FIELDS));

	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_row = field_sel[FSEL_W-1:1];
			ST_PREP: rd_row = cfg.gated;
			ST_SCAN: rd_row = chan_q;
			default: rd_row = chan_q;
		endcase
	end

	assign rd_even = even_q[rd_row];
	assign rd_odd  = odd_q[rd_row];

	// Decimal accumulate with saturation: v*10 + d.
	assign cur  = field_sel[0] ? rd_odd : rd_even;
	assign prod = ({4'b0000, cur} << 3) + ({4'b0000, cur} << 1) + PROD_W'(op.digit);
	assign sat  = (prod > MAXV_EXT) ? {VALUE_BITS{1'b1}} : prod[VALUE_BITS-1:0];

	// Pulse width limited to the period.
	assign odd_ext    = CMP_W'(rd_odd);
	assign period_ext = CMP_W'(cfg.period);
	assign pw_clamped = (odd_ext > period_ext) ? cfg.period : odd_ext[PULSE_W-1:0];

	assign out_free  = ~res_valid_q | res_ready;
	assign gate_oh   = ONE_CH << cfg.gated;
	assign ch_oh     = ONE_CH << chan_q;
	assign rest      = mask_q & ~ch_oh;
	assign blocked   = (rd_even != '0) ? upper_q : lower_q;
	assign tick_next = tick_q + 1'b1;
	assign tick_over = tick_next > TICK_W'(cfg.timeout);
	assign sw_emit   = (op.kind == OP_SWITCH) & op.sw_pressed & en_mask[cfg.gated];
	assign op_pop    = (state_q == ST_IDLE) & op_valid & ~(sw_emit & ~out_free);

	// A new result enters the output register this cycle.
	assign res_load  = ((state_q == ST_IDLE) & op_pop & sw_emit)
		| ((state_q == ST_SCAN) & (mask_q != '0) & mask_q[chan_q] & out_free);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				even_q[r] <= '0;
				odd_q[r]  <= '0;
			end
			idx_q        <= '0;
			dir_q        <= '0;
			mask_q       <= '0;
			frame_seen_q <= 1'b0;
			upper_q      <= 1'b0;
			lower_q      <= 1'b0;
			tick_q       <= '0;
			chan_q       <= '0;
			state_q      <= ST_IDLE;
			mode_q       <= MODE_FRAME;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (res_valid_q && res_ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_pop) begin
						case (op.kind)
							OP_MARK: begin
								for (int r = 0; r < ROWS; r++) begin
									even_q[r] <= '0;
									odd_q[r]  <= '0;
								end
								idx_q <= '0;
							end
							OP_DIGIT: begin
								if (digit_ok) begin
									if (field_sel[0]) begin
										odd_q[rd_row] <= sat;
									end else begin
										even_q[rd_row] <= sat;
									end
								end
							end
							OP_COLON: begin
								if (idx_q < FIELD_IDX_W'(INDEX_SAT)) begin
									idx_q <= idx_q + 1'b1;
								end
							end
							OP_END: begin
								mode_q  <= MODE_FRAME;
								state_q <= ST_PREP;
							end
							OP_TICK: begin
								if (frame_seen_q) begin
									frame_seen_q <= 1'b0;
									tick_q       <= '0;
								end else if (tick_over) begin
									tick_q  <= '0;
									mask_q  <= en_mask;
									chan_q  <= '0;
									mode_q  <= MODE_WDOG;
									state_q <= ST_SCAN;
								end else begin
									tick_q <= tick_next;
								end
							end
							OP_SWITCH: begin
								if (op.sw_sel) begin
									lower_q <= op.sw_pressed;
								end else begin
									upper_q <= op.sw_pressed;
								end
								if (sw_emit) begin
									res_valid_q       <= 1'b1;
									res_q.channel     <= cfg.gated;
									res_q.direction   <= dir_q[cfg.gated];
									res_q.pulse_width <= '0;
									res_q.last        <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					// Block the gated channel when the switch on its side is pressed.
					mask_q  <= en_mask & ~(blocked ? gate_oh : '0);
					chan_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (mask_q == '0) begin
						if (mode_q == MODE_FRAME) begin
							for (int r = 0; r < ROWS; r++) begin
								even_q[r] <= '0;
								odd_q[r]  <= '0;
							end
							idx_q        <= '0;
							frame_seen_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (!mask_q[chan_q]) begin
						chan_q <= chan_q + 1'b1;
					end else if (out_free) begin
						res_valid_q   <= 1'b1;
						res_q.channel <= chan_q;
						res_q.last    <= (rest == '0);
						if (mode_q == MODE_FRAME) begin
							res_q.direction   <= (rd_even != '0);
							res_q.pulse_width <= pw_clamped;
							dir_q[chan_q]     <= (rd_even != '0);
						end else begin
							res_q.direction   <= 1'b0;
							res_q.pulse_width <= '0;
							dir_q[chan_q]     <= 1'b0;
						end
						mask_q <= rest;
						chan_q <= chan_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* dv/amcd_update_checker.sv */
// Update checker for the ASCII motor command decoder testbench.
// Watches requests, register writes and channel updates; predicts and compares updates.
// Depends on amcd_pkg.
module amcd_update_checker
	import amcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [1:0]            s_tuser,   // [1:0] command
	input  logic [15:0]           s_tdata,   // [7:0] rx_byte, [8] switch_select, [9] switch_level
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [23:0]           m_tdata,   // [2:0] channel, [3] direction, [19:4] pulse_width
	input  logic                  m_tlast,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    updates_left
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHAN_LIMIT =
		(NUM_CHANNELS_DEF < MAX_CHANNELS) ? NUM_CHANNELS_DEF : MAX_CHANNELS;
	localparam logic [31:0] VALUE_MAX = (32'd1 << VALUE_BITS_DEF) - 32'd1;

	cfg_t                      cfg_shadow;
	logic [VALUE_BITS_DEF-1:0] field_val [NUM_FIELDS];
	logic [FIELD_IDX_W-1:0]    field_pos;
	logic                      chan_dir [MAX_CHANNELS];
	logic                      frame_done;
	logic [TICK_W-1:0]         tick_cnt;
	logic                      upper_hit;
	logic                      lower_hit;
	result_t                   expected_updates [$];

	function automatic logic chan_on(int c);
		if (c >= CHAN_LIMIT)
			return 1'b0;
		return cfg_shadow.enable_mask[c];
	endfunction

	task automatic clear_frame();
		foreach (field_val[i])
			field_val[i] = '0;
		field_pos = '0;
	endtask

	task automatic add_update(int c, logic dir, logic [PULSE_W-1:0] pw);
		result_t r;
		r.channel     = CH_W'(c);
		r.direction   = dir;
		r.pulse_width = pw;
		r.last        = 1'b0;
		expected_updates.push_back(r);
	endtask

	task automatic decode_request(logic [1:0] cmd, logic [15:0] data);
		int                 first;
		int                 idx;
		logic [7:0]         b;
		logic [31:0]        acc;
		logic               dir;
		logic               pressed;
		logic [PULSE_W-1:0] pw;
		result_t            tail;
		first = expected_updates.size();
		b = data[7:0];
		case (cmd)
			CMD_BYTE: begin
				if (b == CHAR_M) begin
					clear_frame();
				end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
					// digits ahead of the first colon or past the last field go nowhere
					if (field_pos >= 1 && field_pos <= NUM_FIELDS) begin
						idx = int'(field_pos) - 1;
						acc = 32'(field_val[idx]) * 32'd10 + 32'(b) - 32'(CHAR_ZERO);
						field_val[idx] = (acc > VALUE_MAX) ? VALUE_MAX[VALUE_BITS_DEF-1:0]
							: acc[VALUE_BITS_DEF-1:0];
					end
				end else if (b == CHAR_COLON) begin
					if (field_pos < INDEX_SAT)
						field_pos = field_pos + 1'b1;
				end else if (b == CHAR_E) begin
					frame_done = 1'b1;
					for (int c = 0; c < CHAN_LIMIT; c++) begin
						if (chan_on(c)) begin
							dir = (field_val[2*c] != '0);
							// gated channel holds while the switch on its side is pressed
							if (!(c == int'(cfg_shadow.gated) && (dir ? upper_hit : lower_hit))) begin
								pw = (field_val[2*c+1] > cfg_shadow.period) ? cfg_shadow.period
									: field_val[2*c+1];
								chan_dir[c] = dir;
								add_update(c, dir, pw);
							end
						end
					end
					clear_frame();
				end
			end
			CMD_TICK: begin
				if (frame_done) begin
					frame_done = 1'b0;
					tick_cnt   = '0;
				end else begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt > cfg_shadow.timeout) begin
						tick_cnt = '0;
						for (int c = 0; c < CHAN_LIMIT; c++) begin
							if (chan_on(c)) begin
								chan_dir[c] = 1'b0;
								add_update(c, 1'b0, '0);
							end
						end
					end
				end
			end
			CMD_SWITCH: begin
				pressed = ~data[9];
				if (data[8] == 1'b0)
					upper_hit = pressed;
				else
					lower_hit = pressed;
				if (pressed && chan_on(int'(cfg_shadow.gated)))
					add_update(int'(cfg_shadow.gated), chan_dir[cfg_shadow.gated], '0);
			end
			default: ;
		endcase
		if (expected_updates.size() > first) begin
			tail = expected_updates.pop_back();
			tail.last = 1'b1;
			expected_updates.push_back(tail);
		end
	endtask

	task automatic report(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		fail_count++;
	endtask

	task automatic check_update();
		result_t want;
		if (expected_updates.size() == 0) begin
			$display("%0t: unexpected update: expected none, actual ch %0d dir %0d pw %0d last %0d",
				$time, m_tdata[2:0], m_tdata[3], m_tdata[19:4], m_tlast);
			fail_count++;
		end else begin
			want = expected_updates.pop_front();
			if (m_tdata[2:0] !== want.channel)
				report("channel", 32'(want.channel), 32'(m_tdata[2:0]));
			if (m_tdata[3] !== want.direction)
				report("direction", 32'(want.direction), 32'(m_tdata[3]));
			if (m_tdata[19:4] !== want.pulse_width)
				report("pulse_width", 32'(want.pulse_width), 32'(m_tdata[19:4]));
			if (m_tlast !== want.last)
				report("last", 32'(want.last), 32'(m_tlast));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_shadow.enable_mask = RST_ENABLE_MASK;
			cfg_shadow.timeout     = RST_TIMEOUT;
			cfg_shadow.period      = RST_PERIOD;
			cfg_shadow.gated       = RST_GATED;
			clear_frame();
			foreach (chan_dir[i])
				chan_dir[i] = 1'b0;
			frame_done = 1'b0;
			tick_cnt   = '0;
			upper_hit  = 1'b0;
			lower_hit  = 1'b0;
			expected_updates.delete();
			fail_count   = 0;
			updates_left = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_update();
			if (cfg_wen) begin
				case (cfg_index)
					REG_ENABLE_MASK: cfg_shadow.enable_mask = cfg_wdata[MAX_CHANNELS-1:0];
					REG_TIMEOUT:     cfg_shadow.timeout     = cfg_wdata[TIMEOUT_W-1:0];
					REG_PERIOD:      cfg_shadow.period      = cfg_wdata[PULSE_W-1:0];
					REG_GATED:       cfg_shadow.gated       = cfg_wdata[CH_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_request(s_tuser, s_tdata);
			updates_left = expected_updates.size();
		end
	end

endmodule

/* dv/ascii_motor_command_decoder_top_tb.sv */
// Top of the ASCII motor command decoder testbench: clock, reset, stimulus and verdict.
// Depends on amcd_pkg, ascii_motor_command_decoder_top and amcd_update_checker.
module ascii_motor_command_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import amcd_pkg::*;

	// Command code the block leaves unused; it must be ignored.
	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	// Switch select and pin level codes (pins are pulled up, so low means pressed).
	localparam logic       SW_UPPER     = 1'b0;
	localparam logic       SW_LOWER     = 1'b1;
	localparam logic       PIN_PRESSED  = 1'b0;
	localparam logic       PIN_RELEASED = 1'b1;
	// Long receiver hold-off that fills the op queue and stalls the input side.
	localparam int         LONG_HOLD     = 400;
	// Settling wait that lets the back end finish a scan that produces nothing.
	localparam int         SETTLE_CYCLES = 40;
	localparam int         CYCLE_LIMIT   = 300000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [1:0]            s_tuser;   // [1:0] command
	logic [15:0]           s_tdata;   // [7:0] rx_byte, [8] switch_select, [9] switch_level
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // [2:0] channel, [3] direction, [19:4] pulse_width
	logic                  m_tlast;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int updates_left;
	int requests_sent;
	int cycle_count;
	bit steady;       // set for the closing stretch: no idling on either side
	bit hold_ready;   // asks the receiver process for one long hold-off

	ascii_motor_command_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	amcd_update_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tuser      (s_tuser),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.updates_left (updates_left)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the whole run: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: drop tready in random bursts, honor one long hold-off on request,
	// and stay ready throughout the steady stretch.
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_ready) begin
				hold_ready = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!steady && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	function automatic logic [7:0] rand_digit();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Offer one request and hold it until the block takes it. Insert an idle
	// burst ahead of about one request in four, except in the steady stretch.
	task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic sel, logic lvl);
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'd0, lvl, sel, b};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		if (cmd != CMD_UNUSED)
			requests_sent++;
	endtask

	// Serial byte with random switch bits, which the block must not care about.
	task automatic send_byte(logic [7:0] b);
		send_item(CMD_BYTE, b, 1'($urandom), 1'($urandom));
	endtask

	// Frame "M:d:p:...:E" with random content. A full frame fills all sixteen
	// fields; otherwise drop the leading 'M' or the closing 'E' now and then,
	// put digits ahead of the first colon, overrun the field count, and
	// scatter stray bytes between fields.
	task automatic send_frame(bit full);
		int n_fields;
		int n_digits;
		if (full || $urandom_range(0, 9) != 0)
			send_byte(CHAR_M);
		if (!full && $urandom_range(0, 3) == 0)
			send_byte(rand_digit());
		if (full)
			n_fields = NUM_FIELDS;
		else if ($urandom_range(0, 7) == 0)
			n_fields = $urandom_range(NUM_FIELDS + 1, NUM_FIELDS + 3);
		else
			n_fields = $urandom_range(0, NUM_FIELDS);
		for (int f = 0; f < n_fields; f++) begin
			send_byte(CHAR_COLON);
			// long runs of digits push past the period and into saturation
			n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
			repeat (n_digits) send_byte(rand_digit());
			if (!full && $urandom_range(0, 19) == 0)
				send_byte(8'($urandom_range(0, 255)));
		end
		if (full || $urandom_range(0, 9) != 0)
			send_byte(CHAR_E);
	endtask

	task automatic send_random_event();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_frame(1'b0);
		else if (pick < 70)
			repeat ($urandom_range(1, 4))
				send_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
		else if (pick < 88)
			send_item(CMD_SWITCH, 8'($urandom), 1'($urandom), 1'($urandom));
		else if (pick < 96)
			send_byte(8'($urandom_range(0, 255)));
		else
			send_item(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic run_phase(int budget);
		int start;
		start = requests_sent;
		while (requests_sent - start < budget)
			send_random_event();
	endtask

	// Drop tvalid, let the checker see the last request, wait for every
	// predicted update, then let a silent scan run out.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (updates_left != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram all registers, only once the block has gone quiet.
	task automatic set_regs(logic [7:0] mask, logic [14:0] timeout, logic [15:0] period,
			logic [2:0] gated);
		wait_idle();
		write_reg(REG_ENABLE_MASK, 16'(mask));
		write_reg(REG_TIMEOUT, 16'(timeout));
		write_reg(REG_PERIOD, period);
		write_reg(REG_GATED, 16'(gated));
	endtask

	initial begin
		string hdr;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= '0;
		s_tdata   <= '0;
		cfg_wen   <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		requests_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset register values.
		// Digit ahead of the first colon is ignored; 99999 saturates the field
		// and then clamps to the period; the fields left out read as zero.
		hdr = "M7:1:99999E";
		for (int i = 0; i < hdr.len(); i++)
			send_byte(hdr[i]);
		// bytes outside the frame alphabet, at both ends of the byte range
		send_byte(8'h00);
		send_byte(8'hFF);
		send_item(CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
		// first tick after a frame only clears the frame flag
		send_item(CMD_TICK, 8'h00, 1'b0, 1'b0);
		// press, press again while held, release
		send_item(CMD_SWITCH, 8'h00, SW_UPPER, PIN_PRESSED);
		send_item(CMD_SWITCH, 8'hFF, SW_UPPER, PIN_PRESSED);
		send_item(CMD_SWITCH, 8'h00, SW_UPPER, PIN_RELEASED);
		// lower pressed blocks the gated channel on a zero direction; this 'E'
		// also parses a frame that never saw a leading 'M'
		send_item(CMD_SWITCH, 8'h00, SW_LOWER, PIN_PRESSED);
		send_byte(CHAR_E);
		send_item(CMD_SWITCH, 8'hFF, SW_LOWER, PIN_RELEASED);

		// Every channel on, widest period, watchdog at a hair trigger.
		set_regs(8'hFF, 15'd2, 16'hFFFF, 3'd0);
		run_phase(12);
		// Hold the receiver off while full frames keep coming: fill up and stall.
		hold_ready = 1'b1;
		repeat (2) send_frame(1'b1);
		run_phase(10);

		// No channel enabled, narrowest period and timeout: nothing may come out.
		set_regs(8'h00, 15'd1, 16'd1, 3'd7);
		run_phase(12);

		// Only the top channel, also the gated one; watchdog at its longest.
		set_regs(8'h80, 15'd32767, 16'd1, 3'd7);
		run_phase(12);

		// Random setting.
		set_regs(8'($urandom), 15'($urandom_range(1, 6)), 16'($urandom_range(1, 65535)),
			3'($urandom));
		run_phase(15);

		// Closing stretch at full rate on both sides.
		set_regs(RST_ENABLE_MASK, 15'd3, RST_PERIOD, 3'($urandom));
		steady = 1'b1;
		run_phase(20);

		wait_idle();
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* sim.f */
src/amcd_pkg.sv
src/amcd_front.sv
src/amcd_queue.sv
src/amcd_back.sv
src/ascii_motor_command_decoder_top.sv
dv/amcd_update_checker.sv
dv/ascii_motor_command_decoder_top_tb.sv
